// ===== hw/rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int PRIO_W    = 31;
  localparam int CAP_W     = 5;
  localparam int ADDR_W    = 3;
  localparam int STATUS_W  = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Register index of the capacity limit
  localparam logic REG_CAP_LIMIT = 1'b0;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  // One stored entry
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t item;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and shifts toward its neighbors.
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      occupied,
  input  logic      left_keep,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  output logic      keep,
  output entry_t    entry
);

  entry_t entry_r;
  entry_t entry_nxt;

  // Stay in place when holding an entry ranked at or above the new one
  assign keep  = occupied && (entry_r.prio >= cmd.item.prio);
  assign entry = entry_r;

  // Take the new item at the insert point, shift right behind it, shift left on remove
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins && !keep) begin
      entry_nxt = left_keep ? cmd.item : left_entry;
    end else if (cmd.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== hw/rtl/sorted_priority_queue_top.sv =====
// Top level of the sorted priority queue: APB register, cell chain and result register.
//
// Input channel (in_valid/in_ready) carries one transaction per operation: in_op
// selects insert or remove, in_item_data and in_item_priority give the entry.
// Output channel (out_valid/out_ready) returns one transaction per operation with
// the status, the removed entry (zero unless removed) and the entry count after it.
// Entries live in a chain of DEPTH cells sorted by descending priority, head in
// cell 0. Every cell compares the new priority in parallel, so an insert or a
// remove finishes in the cycle it is accepted and out_valid rises in the cycle
// after; one operation is taken per cycle, limited by the single result register.
// While the receiver stalls, the result register holds and in_ready drops; the
// next transaction is taken in the same cycle the waiting result leaves.
// Reset (rst_n low, synchronous) empties the queue, drops out_valid and sets
// the capacity limit to 16; slot contents and result fields are not cleared.
// The capacity limit register sits at byte address 0 of the APB port and is to be
// written only while the block is idle; the block itself does not enforce this.
module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [DATA_W-1:0]   in_item_data,
  input  logic [DATA_W-1:0]   in_item_priority,
  // output channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [DATA_W-1:0]   out_data,
  output logic [PRIO_W-1:0]   out_priority,
  output logic [CNT_W-1:0]    out_count
);

  logic [CAP_W-1:0]    cap_r;
  logic [CNT_W-1:0]    fill_r;
  logic [CNT_W-1:0]    fill_nxt;
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] status_nxt;
  entry_t              res_r;
  entry_t              res_nxt;
  logic [CNT_W-1:0]    count_r;

  logic       accept;
  logic       prio_ok;
  logic       is_full;
  logic       ins_go;
  logic       rem_go;
  logic [31:0] eff_limit;
  cell_cmd_t  cmd;

  logic   keep   [DEPTH];
  entry_t cells  [DEPTH];

  // APB register access
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_CAP_LIMIT) ? {27'd0, cap_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1:2] == REG_CAP_LIMIT) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  // Decode the operation
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign prio_ok   = !in_item_priority[DATA_W-1] && (|in_item_priority[PRIO_W-1:0]);
  assign eff_limit = ({27'd0, cap_r} > 32'(DEPTH)) ? 32'(DEPTH) : {27'd0, cap_r};
  assign is_full   = 32'(fill_r) >= eff_limit;
  assign ins_go    = accept && (in_op == OP_INSERT) && prio_ok && !is_full;
  assign rem_go    = accept && (in_op == OP_REMOVE) && (fill_r != '0);

  assign cmd.ins       = ins_go;
  assign cmd.rem       = rem_go;
  assign cmd.item.data = in_item_data;
  assign cmd.item.prio = in_item_priority[PRIO_W-1:0];

  // Chain of cells, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   lk;
    entry_t le;
    entry_t re;
    if (i == 0) begin : g_head
      assign lk = 1'b1;
      assign le = cmd.item;
    end else begin : g_body
      assign lk = keep[i-1];
      assign le = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign re = cells[i];
    end else begin : g_mid
      assign re = cells[i+1];
    end
    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (CNT_W'(i) < fill_r),
      .left_keep   (lk),
      .left_entry  (le),
      .right_entry (re),
      .keep        (keep[i]),
      .entry       (cells[i])
    );
  end

  // Next count and result
  always_comb begin
    fill_nxt   = fill_r;
    status_nxt = ST_INSERTED;
    res_nxt    = '0;
    if (in_op == OP_INSERT) begin
      if (!prio_ok) begin
        status_nxt = ST_REJECTED;
      end else if (is_full) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt = ST_INSERTED;
        fill_nxt   = fill_r + CNT_W'(1);
      end
    end else begin
      if (fill_r == '0) begin
        status_nxt = ST_EMPTY;
      end else begin
        status_nxt = ST_REMOVED;
        res_nxt    = cells[0];
        fill_nxt   = fill_r - CNT_W'(1);
      end
    end
  end

  // Hold the count and the result transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fill_r <= fill_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
      count_r  <= fill_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_data     = res_r.data;
  assign out_priority = res_r.prio;
  assign out_count    = count_r;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= DEPTH)
    else $error("entry count exceeds depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ins_go |=> fill_r == $past(fill_r) + CNT_W'(1))
    else $error("insert did not grow the count");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    rem_go |=> fill_r == $past(fill_r) - CNT_W'(1))
    else $error("remove did not shrink the count");

  a_removed_prio: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_REMOVED) |-> res_r.prio != '0)
    else $error("removed entry has zero priority");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r >= CNT_W'(2)) |-> cells[0].prio >= cells[1].prio)
    else $error("head entry out of order");
`endif

endmodule
